### src/xad_pkg.sv
package xad_pkg;

    localparam int MAX_RECORDS = 256;
    localparam int TBL_AW      = $clog2(MAX_RECORDS);
    localparam int REC_CNT_W   = TBL_AW + 1;

    localparam logic [7:0] KEY_RESET = 8'hF7;
    localparam logic [7:0] END_FLAG  = 8'h80;

    localparam logic [3:0] KIND_MAGIC   = 4'd0;
    localparam logic [3:0] KIND_VERSION = 4'd1;
    localparam logic [3:0] KIND_FLAG    = 4'd2;
    localparam logic [3:0] KIND_NAMELEN = 4'd3;
    localparam logic [3:0] KIND_NAME    = 4'd4;
    localparam logic [3:0] KIND_SIZE    = 4'd5;
    localparam logic [3:0] KIND_TIME    = 4'd6;
    localparam logic [3:0] KIND_BODY    = 4'd7;
    localparam logic [3:0] KIND_IGNORED = 4'd8;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
    localparam logic [2:0] ST_BAD_VERSION = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd3;
    localparam logic [2:0] ST_TRAILING    = 3'd4;
    localparam logic [2:0] ST_STOPPED     = 3'd5;

    typedef struct packed {
        logic       restart;
        logic [7:0] data;
    } byte_item_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] b;
        begin
            case (pos)
                2'd0:    b = 8'hC0;
                2'd1:    b = 8'h4A;
                2'd2:    b = 8'hC0;
                default: b = 8'hBA;
            endcase
            return b;
        end
    endfunction

endpackage

### src/xad_front.sv
module xad_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_restart,
    output logic                push,
    input  logic                q_ready,
    output xad_pkg::byte_item_t push_item
);

    logic [7:0] key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= xad_pkg::KEY_RESET;
        end
        else if (cfg_we)
        begin
            key_reg <= cfg_wdata;
        end
    end

    // decode on the way into the queue
    assign in_ready          = q_ready;
    assign push              = in_valid && q_ready;
    assign push_item.data    = in_byte ^ key_reg;
    assign push_item.restart = in_restart;

endmodule

### src/xad_queue.sv
module xad_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  xad_pkg::byte_item_t push_item,
    output logic                push_ready,
    output logic                pop_valid,
    input  logic                pop,
    output xad_pkg::byte_item_t pop_item
);

    xad_pkg::byte_item_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### src/xad_parser.sv
module xad_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                pop,
    input  xad_pkg::byte_item_t in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic [3:0]          out_kind,
    output logic [7:0]          out_index,
    output logic [31:0]         out_size,
    output logic                out_end,
    output logic                out_done,
    output logic [2:0]          out_status
);

    typedef enum logic [3:0] {
        PH_MAGIC, PH_VERSION, PH_FLAG, PH_NAMELEN, PH_NAME,
        PH_SIZE, PH_TIME, PH_BODY, PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0]  idx;
        logic [30:0] size;
    } tbl_entry_t;

    localparam logic [xad_pkg::REC_CNT_W-1:0] REC_FULL =
        xad_pkg::REC_CNT_W'(xad_pkg::MAX_RECORDS);

    tbl_entry_t tbl [xad_pkg::MAX_RECORDS];
    tbl_entry_t pf_reg;

    phase_t                         phase_reg,   phase_next,   ph;
    logic [3:0]                     fp_reg,      fp_next,      fp;
    logic [7:0]                     nrem_reg,    nrem_next,    nrem;
    logic [31:0]                    acc_reg,     acc_next,     acc;
    logic [xad_pkg::REC_CNT_W-1:0]  seen_reg,    seen_next,    seen;
    logic [xad_pkg::REC_CNT_W-1:0]  stored_reg,  stored_next,  stored;
    logic [xad_pkg::REC_CNT_W-1:0]  be_reg,      be_next,      be;
    logic [30:0]                    brem_reg,    brem_next,    brem;
    logic [7:0]                     cidx_reg,    cidx_next,    cidx;
    logic                           err_reg,     err_next,     err;
    logic [7:0]                     fidx_reg,    fidx_next;
    logic [30:0]                    fsize_reg,   fsize_next;

    logic [3:0]  kind;
    logic [7:0]  idx;
    logic [31:0] rsize;
    logic        rend;
    logic        done;
    logic [2:0]  st;
    logic        wr_en;
    logic [7:0]  d;
    logic [7:0]  cur;
    logic [31:0] acc_new;
    logic [30:0] brem_dec;
    logic [xad_pkg::REC_CNT_W-1:0] be_inc;
    logic [xad_pkg::TBL_AW-1:0]    rd_addr;

    logic        out_valid_reg;
    logic [7:0]  byte_reg;
    logic [3:0]  kind_reg;
    logic [7:0]  index_reg;
    logic [31:0] size_reg;
    logic        end_reg;
    logic        done_reg;
    logic [2:0]  status_reg;

    assign pop = in_valid && (!out_valid_reg || out_ready);
    assign d   = in_item.data;

    always_comb
    begin
        // restart clears the parser before the byte is taken
        ph     = in_item.restart ? PH_MAGIC : phase_reg;
        fp     = in_item.restart ? 4'd0 : fp_reg;
        nrem   = in_item.restart ? 8'd0 : nrem_reg;
        acc    = in_item.restart ? 32'd0 : acc_reg;
        seen   = in_item.restart ? '0 : seen_reg;
        stored = in_item.restart ? '0 : stored_reg;
        be     = in_item.restart ? '0 : be_reg;
        brem   = in_item.restart ? 31'd0 : brem_reg;
        cidx   = cidx_reg;
        err    = in_item.restart ? 1'b0 : err_reg;

        phase_next  = ph;
        fp_next     = fp;
        nrem_next   = nrem;
        acc_next    = acc;
        seen_next   = seen;
        stored_next = stored;
        be_next     = be;
        brem_next   = brem;
        cidx_next   = cidx;
        err_next    = err;
        fidx_next   = fidx_reg;
        fsize_next  = fsize_reg;

        kind  = xad_pkg::KIND_IGNORED;
        idx   = 8'd0;
        rsize = 32'd0;
        rend  = 1'b0;
        done  = 1'b0;
        st    = xad_pkg::ST_OK;
        wr_en = 1'b0;

        cur      = 8'(seen_reg - 1'b1);
        acc_new  = acc | ({24'd0, d} << {fp[1:0], 3'b000});
        brem_dec = (brem != 31'd0) ? brem - 31'd1 : brem;
        be_inc   = be + 1'b1;

        if (err)
        begin
            st = xad_pkg::ST_STOPPED;
        end
        else
        begin
            unique case (ph)
                PH_MAGIC:
                begin
                    kind = xad_pkg::KIND_MAGIC;
                    if (d != xad_pkg::magic_byte(fp[1:0]))
                    begin
                        st       = xad_pkg::ST_BAD_MAGIC;
                        err_next = 1'b1;
                    end
                    else if (fp == 4'd3)
                    begin
                        fp_next    = 4'd0;
                        phase_next = PH_VERSION;
                    end
                    else
                    begin
                        fp_next = fp + 4'd1;
                    end
                end
                PH_VERSION:
                begin
                    kind = xad_pkg::KIND_VERSION;
                    if (d != 8'd0)
                    begin
                        st       = xad_pkg::ST_BAD_VERSION;
                        err_next = 1'b1;
                    end
                    else if (fp == 4'd3)
                    begin
                        fp_next    = 4'd0;
                        phase_next = PH_FLAG;
                    end
                    else
                    begin
                        fp_next = fp + 4'd1;
                    end
                end
                PH_FLAG:
                begin
                    kind = xad_pkg::KIND_FLAG;
                    if (d == xad_pkg::END_FLAG)
                    begin
                        if (stored == '0)
                        begin
                            done       = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            be_next    = '0;
                            brem_next  = fsize_reg;
                            cidx_next  = fidx_reg;
                            phase_next = PH_BODY;
                        end
                    end
                    else
                    begin
                        idx        = seen[7:0];
                        seen_next  = seen + 1'b1;
                        acc_next   = 32'd0;
                        phase_next = PH_NAMELEN;
                    end
                end
                PH_NAMELEN:
                begin
                    kind       = xad_pkg::KIND_NAMELEN;
                    idx        = cur;
                    nrem_next  = d;
                    fp_next    = 4'd0;
                    phase_next = (d == 8'd0) ? PH_SIZE : PH_NAME;
                end
                PH_NAME:
                begin
                    kind      = xad_pkg::KIND_NAME;
                    idx       = cur;
                    nrem_next = (nrem != 8'd0) ? nrem - 8'd1 : nrem;
                    if (nrem_next == 8'd0)
                    begin
                        fp_next    = 4'd0;
                        phase_next = PH_SIZE;
                    end
                end
                PH_SIZE:
                begin
                    kind     = xad_pkg::KIND_SIZE;
                    idx      = cur;
                    acc_next = acc_new;
                    if (fp == 4'd3)
                    begin
                        fp_next    = 4'd0;
                        rsize      = acc_new;
                        phase_next = PH_TIME;
                        if (acc_new != 32'd0 && !acc_new[31])
                        begin
                            if (stored == REC_FULL)
                            begin
                                st       = xad_pkg::ST_TABLE_FULL;
                                err_next = 1'b1;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                stored_next = stored + 1'b1;
                                if (stored == '0)
                                begin
                                    fidx_next  = cur;
                                    fsize_next = acc_new[30:0];
                                end
                            end
                        end
                    end
                    else
                    begin
                        fp_next = fp + 4'd1;
                    end
                end
                PH_TIME:
                begin
                    kind = xad_pkg::KIND_TIME;
                    idx  = cur;
                    if (fp == 4'd7)
                    begin
                        fp_next    = 4'd0;
                        phase_next = PH_FLAG;
                    end
                    else
                    begin
                        fp_next = fp + 4'd1;
                    end
                end
                PH_BODY:
                begin
                    kind = xad_pkg::KIND_BODY;
                    if (be < stored)
                    begin
                        idx       = cidx;
                        brem_next = brem_dec;
                        if (brem_dec == 31'd0)
                        begin
                            rend    = 1'b1;
                            be_next = be_inc;
                            if (be_inc >= stored)
                            begin
                                done       = 1'b1;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                // next record comes from the prefetched entry
                                brem_next = pf_reg.size;
                                cidx_next = pf_reg.idx;
                            end
                        end
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                        kind       = xad_pkg::KIND_IGNORED;
                        st         = xad_pkg::ST_TRAILING;
                    end
                end
                default:
                begin
                    st = xad_pkg::ST_TRAILING;
                end
            endcase
        end
    end

    // prefetch holds the entry after the one being played out
    assign rd_addr = pop ? be_next[xad_pkg::TBL_AW-1:0] + 1'b1
                         : be_reg[xad_pkg::TBL_AW-1:0] + 1'b1;

    always_ff @(posedge clk)
    begin
        if (pop && wr_en)
        begin
            tbl[stored[xad_pkg::TBL_AW-1:0]] <= '{idx: cur, size: acc_new[30:0]};
        end
        pf_reg <= tbl[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAGIC;
            fp_reg        <= 4'd0;
            nrem_reg      <= 8'd0;
            acc_reg       <= 32'd0;
            seen_reg      <= '0;
            stored_reg    <= '0;
            be_reg        <= '0;
            brem_reg      <= 31'd0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg     <= phase_next;
                fp_reg        <= fp_next;
                nrem_reg      <= nrem_next;
                acc_reg       <= acc_next;
                seen_reg      <= seen_next;
                stored_reg    <= stored_next;
                be_reg        <= be_next;
                brem_reg      <= brem_next;
                err_reg       <= err_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cidx_reg   <= cidx_next;
            fidx_reg   <= fidx_next;
            fsize_reg  <= fsize_next;
            byte_reg   <= d;
            kind_reg   <= kind;
            index_reg  <= idx;
            size_reg   <= rsize;
            end_reg    <= rend;
            done_reg   <= done;
            status_reg <= st;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = byte_reg;
    assign out_kind   = kind_reg;
    assign out_index  = index_reg;
    assign out_size   = size_reg;
    assign out_end    = end_reg;
    assign out_done   = done_reg;
    assign out_status = status_reg;

    a_end_is_body: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && end_reg |-> kind_reg == xad_pkg::KIND_BODY)
        else $error("record end on a non-body byte");

    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |->
            kind_reg == xad_pkg::KIND_BODY || kind_reg == xad_pkg::KIND_FLAG)
        else $error("archive done on a wrong kind");

    a_body_stored: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> stored_reg != '0)
        else $error("body phase with no stored record");

    a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= REC_FULL)
        else $error("record table overrun");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(byte_reg))
        else $error("result lost under stall");

endmodule

### src/xor_archive_stream_deframer_core.sv
// A transfer accepted at the input is written into the queue, then registered in the parser's output stage.
// Throughput: one byte per cycle while the output is not stalled; the parser takes one byte a step and the
// record table is read one entry ahead through a registered prefetch.
// A two-entry queue between decode and parser lets either side stall alone.
// Reset (rst_n, async, low) sets the key to 0xF7, the parser to the magic phase
// and empties the queue; the record table is not cleared.
module xor_archive_stream_deframer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    input  logic        s_axis_tuser,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] decoded_byte, [15:8] record_index,
                                        // [47:16] record_size
    output logic [7:0]  m_axis_tuser,   // [3:0] byte_kind, [4] archive_done, [7:5] status
    output logic        m_axis_tlast    // record_end
);

    xad_pkg::byte_item_t push_item;
    xad_pkg::byte_item_t pop_item;
    logic push;
    logic q_ready;
    logic pop_valid;
    logic pop;
    logic [7:0]  out_byte;
    logic [3:0]  out_kind;
    logic [7:0]  out_index;
    logic [31:0] out_size;
    logic        out_done;
    logic [2:0]  out_status;

    xad_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_restart (s_axis_tuser),
        .push       (push),
        .q_ready    (q_ready),
        .push_item  (push_item)
    );

    xad_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (q_ready),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_item   (pop_item)
    );

    xad_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pop_valid),
        .pop        (pop),
        .in_item    (pop_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (out_byte),
        .out_kind   (out_kind),
        .out_index  (out_index),
        .out_size   (out_size),
        .out_end    (m_axis_tlast),
        .out_done   (out_done),
        .out_status (out_status)
    );

    assign m_axis_tdata = {out_size, out_index, out_byte};
    assign m_axis_tuser = {out_status, out_done, out_kind};

endmodule

### bench/tb.sv
module tb;

    localparam int WD_LIMIT = 3000;

    typedef enum logic [3:0] {
        P_MAGIC, P_VERSION, P_FLAG, P_NAMELEN, P_NAME, P_SIZE, P_TIME, P_BODY, P_DONE
    } parse_phase_t;

    typedef struct {
        bit [7:0]  data;
        bit [3:0]  kind;
        bit [7:0]  idx;
        bit [31:0] size;
        bit        last;
        bit        done;
        bit [2:0]  st;
    } deframed_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] stream_byte
    logic        s_axis_tuser = 1'b0;    // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;           // [7:0] decoded_byte, [15:8] record_index,
                                         // [47:16] record_size
    logic [7:0]  m_axis_tuser;           // [3:0] byte_kind, [4] archive_done, [7:5] status
    logic        m_axis_tlast;           // record_end

    xor_archive_stream_deframer_core i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #10 clk = ~clk;

    xad_pkg::byte_item_t raw_q[$];
    deframed_t    deframed_q[$];
    int           send_idle = 37;
    int           recv_idle = 84;
    logic [7:0]   enc_key = xad_pkg::KEY_RESET;
    bit           took_in = 1'b0;
    int           n_fail = 0;
    int           n_results = 0;
    int           n_archives = 0;
    int           n_errors_seen = 0;
    int           wd_count = 0;

    // parser copy
    logic [7:0]   key_q = xad_pkg::KEY_RESET;
    parse_phase_t ph;
    int           fpos, name_rem, seen, stored, b_entry;
    logic [31:0]  acc, b_rem;
    logic [7:0]   tbl_idx[xad_pkg::MAX_RECORDS];
    logic [31:0]  tbl_sz[xad_pkg::MAX_RECORDS];
    bit           err;

    function automatic void clear_parser();
        ph = P_MAGIC;
        fpos = 0;
        name_rem = 0;
        acc = '0;
        seen = 0;
        stored = 0;
        b_entry = 0;
        b_rem = '0;
        err = 1'b0;
    endfunction

    function automatic deframed_t deframe(input xad_pkg::byte_item_t it);
        deframed_t e;
        logic [7:0] cur;
        e = '{data: it.data ^ key_q, kind: xad_pkg::KIND_IGNORED, idx: 8'h00,
              size: 32'h0, last: 1'b0, done: 1'b0, st: xad_pkg::ST_OK};
        cur = 8'(seen - 1);
        if (it.restart)
            clear_parser();
        if (err)
        begin
            e.st = xad_pkg::ST_STOPPED;
        end
        else
        begin
            case (ph)
                P_MAGIC:
                begin
                    e.kind = xad_pkg::KIND_MAGIC;
                    if (e.data != xad_pkg::magic_byte(2'(fpos)))
                    begin
                        e.st = xad_pkg::ST_BAD_MAGIC;
                        err = 1'b1;
                    end
                    else if (++fpos >= 4)
                    begin
                        fpos = 0;
                        ph = P_VERSION;
                    end
                end
                P_VERSION:
                begin
                    e.kind = xad_pkg::KIND_VERSION;
                    if (e.data != 8'h00)
                    begin
                        e.st = xad_pkg::ST_BAD_VERSION;
                        err = 1'b1;
                    end
                    else if (++fpos >= 4)
                    begin
                        fpos = 0;
                        ph = P_FLAG;
                    end
                end
                P_FLAG:
                begin
                    e.kind = xad_pkg::KIND_FLAG;
                    if (e.data == xad_pkg::END_FLAG)
                    begin
                        if (stored == 0)
                        begin
                            e.done = 1'b1;
                            ph = P_DONE;
                        end
                        else
                        begin
                            b_entry = 0;
                            b_rem = tbl_sz[0];
                            ph = P_BODY;
                        end
                    end
                    else
                    begin
                        e.idx = 8'(seen);
                        seen++;
                        acc = '0;
                        ph = P_NAMELEN;
                    end
                end
                P_NAMELEN:
                begin
                    e.kind = xad_pkg::KIND_NAMELEN;
                    e.idx = cur;
                    name_rem = int'(e.data);
                    fpos = 0;
                    ph = (e.data == 8'h00) ? P_SIZE : P_NAME;
                end
                P_NAME:
                begin
                    e.kind = xad_pkg::KIND_NAME;
                    e.idx = cur;
                    if (name_rem > 0)
                        name_rem--;
                    if (name_rem == 0)
                    begin
                        fpos = 0;
                        ph = P_SIZE;
                    end
                end
                P_SIZE:
                begin
                    e.kind = xad_pkg::KIND_SIZE;
                    e.idx = cur;
                    acc = acc | (32'(e.data) << (8 * (fpos % 4)));
                    if (++fpos >= 4)
                    begin
                        fpos = 0;
                        e.size = acc;
                        ph = P_TIME;
                        if (acc != 0 && !acc[31])
                        begin
                            if (stored >= xad_pkg::MAX_RECORDS)
                            begin
                                e.st = xad_pkg::ST_TABLE_FULL;
                                err = 1'b1;
                            end
                            else
                            begin
                                tbl_idx[stored] = 8'(seen - 1);
                                tbl_sz[stored] = acc;
                                stored++;
                            end
                        end
                    end
                end
                P_TIME:
                begin
                    e.kind = xad_pkg::KIND_TIME;
                    e.idx = cur;
                    if (++fpos >= 8)
                    begin
                        fpos = 0;
                        ph = P_FLAG;
                    end
                end
                P_BODY:
                begin
                    e.kind = xad_pkg::KIND_BODY;
                    if (b_entry < stored)
                    begin
                        e.idx = tbl_idx[b_entry];
                        if (b_rem > 0)
                            b_rem--;
                        if (b_rem == 0)
                        begin
                            e.last = 1'b1;
                            b_entry++;
                            if (b_entry >= stored)
                            begin
                                e.done = 1'b1;
                                ph = P_DONE;
                            end
                            else
                            begin
                                b_rem = tbl_sz[b_entry];
                            end
                        end
                    end
                    else
                    begin
                        ph = P_DONE;
                        e.kind = xad_pkg::KIND_IGNORED;
                        e.st = xad_pkg::ST_TRAILING;
                    end
                end
                default: e.st = xad_pkg::ST_TRAILING;
            endcase
        end
        return e;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endtask

    // input and output monitor, predictor and watchdog
    always @(posedge clk)
    begin
        deframed_t e;
        took_in <= s_axis_tvalid && s_axis_tready;
        if (cfg_we)
            key_q = cfg_wdata;
        if (s_axis_tvalid && s_axis_tready)
        begin
            e = deframe('{restart: s_axis_tuser, data: s_axis_tdata});
            if (e.st != xad_pkg::ST_OK && e.st != xad_pkg::ST_STOPPED)
                n_errors_seen++;
            deframed_q.push_back(e);
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (deframed_q.size() == 0)
            begin
                $error("result with no expectation pending");
                n_fail++;
            end
            else
            begin
                e = deframed_q.pop_front();
                check_field("decoded_byte", 32'(e.data), 32'(m_axis_tdata[7:0]));
                check_field("record_index", 32'(e.idx), 32'(m_axis_tdata[15:8]));
                check_field("record_size", e.size, m_axis_tdata[47:16]);
                check_field("byte_kind", 32'(e.kind), 32'(m_axis_tuser[3:0]));
                check_field("archive_done", 32'(e.done), 32'(m_axis_tuser[4]));
                check_field("status", 32'(e.st), 32'(m_axis_tuser[7:5]));
                check_field("record_end", 32'(e.last), 32'(m_axis_tlast));
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (raw_q.size() == 0 && deframed_q.size() == 0 && !s_axis_tvalid))
            wd_count <= 0;
        else
            wd_count <= wd_count + 1;
        if (wd_count >= WD_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // driver
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
        if (rst_n && (!s_axis_tvalid || took_in))
        begin
            if (raw_q.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                xad_pkg::byte_item_t it;
                it = raw_q.pop_front();
                s_axis_tdata  <= it.data;
                s_axis_tuser  <= it.restart;
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic put(input logic [7:0] plain, input bit rs = 1'b0);
        raw_q.push_back('{restart: rs, data: plain ^ enc_key});
    endtask

    // kinds of archive: 0 good, 1 bad magic, 2 bad version, 3 trailing bytes,
    // 4 cut short, 5 table overflow
    task automatic archive(input int nrec, input int kind);
        int sizes[$];
        int badpos, nl, sz;
        logic [31:0] szw;
        logic [7:0] fl;
        n_archives++;
        badpos = $urandom_range(3);
        for (int i = 0; i < 4; i++)
        begin
            if (kind == 1 && i == badpos)
            begin
                put(xad_pkg::magic_byte(2'(i)) ^ 8'(1 << $urandom_range(7)), i == 0);
                repeat ($urandom_range(1, 3)) put(8'($urandom));
                return;
            end
            put(xad_pkg::magic_byte(2'(i)), i == 0);
        end
        for (int i = 0; i < 4; i++)
        begin
            if (kind == 2 && i == badpos)
            begin
                put(8'($urandom_range(1, 255)));
                repeat ($urandom_range(1, 3)) put(8'($urandom));
                return;
            end
            put(8'h00);
        end
        for (int r = 0; r < nrec; r++)
        begin
            fl = 8'($urandom);
            put(fl == xad_pkg::END_FLAG ? 8'h00 : fl);
            nl = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(4);
            if (kind == 5)
                nl = 0;
            put(8'(nl));
            if (kind == 4 && r == nrec - 1)
                return;
            repeat (nl) put(8'($urandom));
            case ($urandom_range(9))
                0: szw = 32'h0;
                1: szw = {1'b1, 31'($urandom)};
                default: szw = $urandom_range(1, 5);
            endcase
            if (kind == 5)
                szw = 32'd1;
            for (int i = 0; i < 4; i++)
                put(szw[8*i +: 8]);
            if (kind == 5 && r == nrec - 1)
            begin
                repeat (3) put(8'($urandom));
                return;
            end
            repeat (8) put(8'($urandom));
            if (szw != 0 && !szw[31])
                sizes.push_back(int'(szw));
        end
        put(xad_pkg::END_FLAG);
        foreach (sizes[k])
        begin
            sz = sizes[k];
            repeat (sz) put(8'($urandom));
        end
        if (kind == 3)
            repeat ($urandom_range(1, 3)) put(8'($urandom));
    endtask

    task automatic random_archives(input int n_bytes);
        int start;
        int r;
        start = raw_q.size();
        while (raw_q.size() - start < n_bytes)
        begin
            r = $urandom_range(19);
            case (r)
                0: archive(1, 1);
                1: archive(1, 2);
                2: archive($urandom_range(1, 3), 4);
                3: archive($urandom_range(0, 3), 3);
                4: repeat ($urandom_range(1, 4)) put(8'($urandom), $urandom_range(7) == 0);
                default: archive($urandom_range(0, 4), 0);
            endcase
        end
    endtask

    task automatic drain();
        wait (raw_q.size() == 0 && !s_axis_tvalid && deframed_q.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_key(input logic [7:0] k);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= k;
        @(negedge clk);
        cfg_we    <= 1'b0;
        enc_key = k;
    endtask

    initial
    begin
        clear_parser();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed: good archives, then bad magic, bad version and trailing bytes
        archive(2, 0);
        archive(0, 0);
        archive(1, 1);
        archive(1, 2);
        archive(1, 3);
        random_archives(200);
        drain();

        send_idle = 84;
        recv_idle = 37;
        write_key(8'h00);
        random_archives(200);
        drain();

        send_idle = 0;
        recv_idle = 0;
        write_key(8'hFF);
        random_archives(120);
        drain();
        write_key(8'($urandom));
        random_archives(60);
        drain();

        $display("tb: %0d archives, %0d result transfers, %0d error statuses, 4 keys",
                 n_archives, n_results, n_errors_seen);
        if (n_fail == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
